// ===== rtl/imtq_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed max task queue package
// Shared types and constants for the task table, its input queue and scanner.
// ----------------------------------------------------------------------------
package imtq_pkg;

    localparam int TASK_SLOTS  = 256;
    localparam int SLOT_W      = $clog2(TASK_SLOTS);
    localparam int SCAN_CNT_W  = $clog2(TASK_SLOTS + 1);
    localparam int OWNER_W     = 16;
    localparam int PRIO_W      = 31;
    localparam int TASK_ID_W   = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_EDIT   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_EXEC   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic                in_range;
        logic [OWNER_W-1:0]  owner;
        logic [SLOT_W-1:0]   slot;
        logic [PRIO_W-1:0]   prio;
    } item_t;

endpackage

// ===== rtl/indexed_max_task_queue_core.sv =====
// ----------------------------------------------------------------------------
// Indexed max task queue core
// Task table keyed by task id with add, edit, remove and execute-top words.
// ----------------------------------------------------------------------------
// Every input word yields one result word. Add, edit and remove words can
// follow one another every cycle while the result register can take their
// results. An execute-top word scans the whole table through the single read
// port of the priority memory, one slot per cycle, then goes through the
// finish, owner and result states before its result is offered. A two-word
// queue in front of the table takes input words during a scan until it
// fills, and the result register frees the table while a result waits.
module indexed_max_task_queue_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [15:0] s_owner_id,
    input  logic [7:0]  s_task_slot,
    input  logic [30:0] s_task_priority,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [15:0] m_top_owner
);
    import imtq_pkg::*;

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    imtq_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_owner_id      (s_owner_id),
        .s_task_slot     (s_task_slot),
        .s_task_priority (s_task_priority),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop)
    );

    imtq_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_found     (m_found),
        .m_top_owner (m_top_owner)
    );

endmodule

// ===== rtl/imtq_front.sv =====
// ----------------------------------------------------------------------------
// Indexed max task queue front end
// Accepts input words, checks the task id against the table and queues them.
// ----------------------------------------------------------------------------
module imtq_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_op,
    input  logic [15:0]               s_owner_id,
    input  logic [7:0]                s_task_slot,
    input  logic [30:0]               s_task_priority,
    output logic                      q_valid,
    output imtq_pkg::item_t           q_item,
    input  logic                      q_pop
);
    import imtq_pkg::*;

    item_t               queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push;
    item_t               in_item;

    assign s_ready = (count_reg < QCNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_item  = queue_mem[rd_ptr_reg];

    always_comb begin
        in_item.op       = op_t'(s_op);
        in_item.in_range = (32'(s_task_slot) < TASK_SLOTS);
        in_item.owner    = s_owner_id;
        in_item.slot     = SLOT_W'(s_task_slot);
        in_item.prio     = s_task_priority;
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (q_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= in_item;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> count_reg != '0)
        else $error("Queue popped while empty.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !q_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("Queue fill level did not rise on a push.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("Queue fill level exceeds its depth.");

endmodule

// ===== rtl/imtq_back.sv =====
// ----------------------------------------------------------------------------
// Indexed max task queue back end
// Holds the task table, applies updates and scans for the top live task.
// ----------------------------------------------------------------------------
module imtq_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    input  imtq_pkg::item_t           q_item,
    output logic                      q_pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_found,
    output logic [15:0]               m_top_owner
);
    import imtq_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_FINISH = 5'b00100,
        ST_OWNER  = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [PRIO_W-1:0]       prio_mem  [TASK_SLOTS];
    logic [OWNER_W-1:0]      owner_mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0]   live_reg;
    logic [TASK_SLOTS-1:0]   owner_ok_reg;

    logic [SCAN_CNT_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic [SLOT_W-1:0]       scan_idx;
    logic [PRIO_W-1:0]       prio_rd_reg;
    logic                    cand_live_reg;
    logic [SLOT_W-1:0]       cand_slot_reg;
    logic                    cand_vld_reg;
    logic                    have_reg, have_next;
    logic [PRIO_W-1:0]       best_prio_reg, best_prio_next;
    logic [SLOT_W-1:0]       best_slot_reg, best_slot_next;
    logic [OWNER_W-1:0]      owner_rd_reg;
    logic                    owner_hit_reg;

    logic                    m_valid_reg, m_valid_next;
    logic                    m_found_reg, m_found_next;
    logic [OWNER_W-1:0]      m_top_owner_reg, m_top_owner_next;
    logic                    out_free;
    logic                    do_update;

    assign scan_idx    = scan_cnt_reg[SLOT_W-1:0];
    assign out_free    = !m_valid_reg || m_ready;
    assign m_valid     = m_valid_reg;
    assign m_found     = m_found_reg;
    assign m_top_owner = m_top_owner_reg;

    always_comb begin
        state_next       = state_reg;
        scan_cnt_next    = scan_cnt_reg;
        have_next        = have_reg;
        best_prio_next   = best_prio_reg;
        best_slot_next   = best_slot_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_found_next     = m_found_reg;
        m_top_owner_next = m_top_owner_reg;
        q_pop            = 1'b0;
        do_update        = 1'b0;

        if (cand_vld_reg && cand_live_reg && (!have_reg || prio_rd_reg >= best_prio_reg)) begin
            have_next      = 1'b1;
            best_prio_next = prio_rd_reg;
            best_slot_next = cand_slot_reg;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_item.op == OP_EXEC) begin
                        q_pop         = 1'b1;
                        scan_cnt_next = '0;
                        have_next     = 1'b0;
                        state_next    = ST_SCAN;
                    end else if (out_free) begin
                        q_pop            = 1'b1;
                        do_update        = q_item.in_range;
                        m_valid_next     = 1'b1;
                        m_found_next     = 1'b0;
                        m_top_owner_next = '0;
                    end
                end
            end
            ST_SCAN: begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == SCAN_CNT_W'(TASK_SLOTS - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                state_next = ST_OWNER;
            end
            ST_OWNER: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_found_next     = have_reg;
                    m_top_owner_next = (have_reg && owner_hit_reg) ? owner_rd_reg : '0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            live_reg     <= '0;
            owner_ok_reg <= '0;
            cand_vld_reg <= 1'b0;
            have_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cand_vld_reg <= (state_reg == ST_SCAN);
            have_reg     <= have_next;
            m_valid_reg  <= m_valid_next;
            if (do_update) begin
                case (q_item.op)
                    OP_ADD: begin
                        live_reg[q_item.slot]     <= 1'b1;
                        owner_ok_reg[q_item.slot] <= 1'b1;
                    end
                    OP_EDIT: begin
                        live_reg[q_item.slot] <= 1'b1;
                    end
                    OP_REMOVE: begin
                        live_reg[q_item.slot] <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (state_reg == ST_OWNER && have_reg) begin
                live_reg[best_slot_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_cnt_reg    <= scan_cnt_next;
        best_prio_reg   <= best_prio_next;
        best_slot_reg   <= best_slot_next;
        m_found_reg     <= m_found_next;
        m_top_owner_reg <= m_top_owner_next;
        cand_live_reg   <= live_reg[scan_idx];
        cand_slot_reg   <= scan_idx;
        owner_hit_reg   <= owner_ok_reg[best_slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (do_update && (q_item.op == OP_ADD || q_item.op == OP_EDIT)) begin
            prio_mem[q_item.slot] <= q_item.prio;
        end
        prio_rd_reg <= prio_mem[scan_idx];
    end

    always_ff @(posedge aclk) begin
        if (do_update && q_item.op == OP_ADD) begin
            owner_mem[q_item.slot] <= q_item.owner;
        end
        owner_rd_reg <= owner_mem[best_slot_reg];
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> scan_cnt_reg < SCAN_CNT_W'(TASK_SLOTS))
        else $error("Scan counter ran past the end of the table.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> m_top_owner_reg == '0)
        else $error("Owner reported without a found task.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OWNER && have_reg) |=> !live_reg[$past(best_slot_reg)])
        else $error("Executed task is still live.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == ST_IDLE)
        else $error("Word taken from the queue while a scan is running.");

endmodule

// ===== verif/indexed_max_task_queue_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed max task queue core testbench
// Sends add, edit, remove and execute-top words in bursts while the result
// side stalls in changing patterns. Each result word is checked against its
// fixed directed row or a behavioural task table kept by this bench itself.
// ----------------------------------------------------------------------------
module indexed_max_task_queue_core_tb;
    import imtq_pkg::*;

    localparam int RANDOM_WORDS  = 1000;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = TASK_SLOTS + 40;
    localparam int REPORT_MAX    = 10;
    localparam int DIRECTED_ROWS = 25;

    typedef struct packed {
        logic               found;
        logic [OWNER_W-1:0] owner;
    } task_result_t;

    typedef struct packed {
        op_t                  op;
        logic [OWNER_W-1:0]   owner;
        logic [TASK_ID_W-1:0] slot;
        logic [PRIO_W-1:0]    prio;
        logic                 fixed;
        logic                 found;
        logic [OWNER_W-1:0]   top_owner;
    } directed_row_t;

    localparam directed_row_t DIRECTED_WORDS [DIRECTED_ROWS] = '{
        '{OP_EXEC,   16'h0000, 8'h00, 31'h00000000, 1'b1, 1'b0, 16'h0000},
        '{OP_EDIT,   16'h9999, 8'h07, 31'h00000005, 1'b1, 1'b0, 16'h0000},
        '{OP_EXEC,   16'h0000, 8'h00, 31'h00000000, 1'b1, 1'b1, 16'h0000},
        '{OP_REMOVE, 16'h0000, 8'h09, 31'h00000000, 1'b1, 1'b0, 16'h0000},
        '{OP_ADD,    16'hFFFF, 8'hFF, 31'h7FFFFFFF, 1'b1, 1'b0, 16'h0000},
        '{OP_ADD,    16'h0000, 8'h00, 31'h00000000, 1'b1, 1'b0, 16'h0000},
        '{OP_ADD,    16'h1234, 8'h0A, 31'h7FFFFFFF, 1'b1, 1'b0, 16'h0000},
        '{OP_EXEC,   16'hFFFF, 8'hFF, 31'h7FFFFFFF, 1'b1, 1'b1, 16'hFFFF},
        '{OP_EXEC,   16'h0000, 8'h00, 31'h00000000, 1'b1, 1'b1, 16'h1234},
        '{OP_EXEC,   16'h0000, 8'h00, 31'h00000000, 1'b1, 1'b1, 16'h0000},
        '{OP_EXEC,   16'h0000, 8'h00, 31'h00000000, 1'b1, 1'b0, 16'h0000},
        '{OP_ADD,    16'hAAAA, 8'h55, 31'h2AAAAAAA, 1'b0, 1'b0, 16'h0000},
        '{OP_ADD,    16'h5555, 8'hAA, 31'h55555555, 1'b0, 1'b0, 16'h0000},
        '{OP_EDIT,   16'h7777, 8'h55, 31'h7FFFFFFE, 1'b0, 1'b0, 16'h0000},
        '{OP_ADD,    16'h0F0F, 8'hAA, 31'h00000001, 1'b0, 1'b0, 16'h0000},
        '{OP_REMOVE, 16'h0000, 8'h55, 31'h00000000, 1'b0, 1'b0, 16'h0000},
        '{OP_EXEC,   16'h0000, 8'h00, 31'h00000000, 1'b0, 1'b0, 16'h0000},
        '{OP_ADD,    16'h0003, 8'h03, 31'h00000064, 1'b0, 1'b0, 16'h0000},
        '{OP_ADD,    16'h0004, 8'h03, 31'h00000064, 1'b0, 1'b0, 16'h0000},
        '{OP_ADD,    16'h0005, 8'h02, 31'h00000064, 1'b0, 1'b0, 16'h0000},
        '{OP_EDIT,   16'h0000, 8'hC8, 31'h00000000, 1'b0, 1'b0, 16'h0000},
        '{OP_EXEC,   16'h0000, 8'h00, 31'h00000000, 1'b0, 1'b0, 16'h0000},
        '{OP_EXEC,   16'h0000, 8'h00, 31'h00000000, 1'b0, 1'b0, 16'h0000},
        '{OP_EXEC,   16'h0000, 8'h00, 31'h00000000, 1'b0, 1'b0, 16'h0000},
        '{OP_EXEC,   16'h0000, 8'h00, 31'h00000000, 1'b0, 1'b0, 16'h0000}
    };

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_op            = 2'd0;
    logic [15:0]          s_owner_id      = 16'd0;
    logic [7:0]           s_task_slot     = 8'd0;
    logic [30:0]          s_task_priority = 31'd0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic                 m_found;
    logic [15:0]          m_top_owner;

    logic                 slot_live  [TASK_SLOTS];
    logic [PRIO_W-1:0]    slot_prio  [TASK_SLOTS];
    logic [OWNER_W-1:0]   slot_owner [TASK_SLOTS];
    task_result_t         owed_results [$];

    int                   fault_count   = 0;
    int                   idle_cycles   = 0;
    int                   words_sent    = 0;
    int                   results_seen  = 0;
    int                   burst_left    = 0;
    int                   exec_hits     = 0;
    int                   exec_empty    = 0;
    int                   ops_sent [4];
    logic [15:0]          stall_pattern = 16'hFFFF;
    int                   pattern_age   = 0;

    indexed_max_task_queue_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_owner_id      (s_owner_id),
        .s_task_slot     (s_task_slot),
        .s_task_priority (s_task_priority),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_found         (m_found),
        .m_top_owner     (m_top_owner)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic task_result_t run_task_word(op_t op, logic [OWNER_W-1:0] owner,
            logic [TASK_ID_W-1:0] slot, logic [PRIO_W-1:0] prio);
        task_result_t res;
        logic         have;
        int           best;
        res  = '0;
        have = 1'b0;
        best = 0;
        case (op)
            OP_ADD: begin
                if (int'(slot) < TASK_SLOTS) begin
                    slot_owner[slot] = owner;
                    slot_prio[slot]  = prio;
                    slot_live[slot]  = 1'b1;
                end
            end
            OP_EDIT: begin
                if (int'(slot) < TASK_SLOTS) begin
                    slot_prio[slot] = prio;
                    slot_live[slot] = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (int'(slot) < TASK_SLOTS) begin
                    slot_live[slot] = 1'b0;
                end
            end
            default: begin
                for (int i = 0; i < TASK_SLOTS; i++) begin
                    if (slot_live[i] && (!have || slot_prio[i] >= slot_prio[best])) begin
                        have = 1'b1;
                        best = i;
                    end
                end
                if (have) begin
                    slot_live[best] = 1'b0;
                    res.found       = 1'b1;
                    res.owner       = slot_owner[best];
                    exec_hits++;
                end else begin
                    exec_empty++;
                end
            end
        endcase
        return res;
    endfunction

    function automatic logic [TASK_ID_W-1:0] pick_slot();
        if ($urandom_range(0, 1) == 0) begin
            return TASK_ID_W'($urandom_range(0, 7));
        end
        return TASK_ID_W'($urandom_range(0, TASK_SLOTS - 1));
    endfunction

    function automatic logic [PRIO_W-1:0] pick_prio();
        case ($urandom_range(0, 5))
            0: return PRIO_W'($urandom_range(0, 3));
            1: return '0;
            2: return '1;
            default: return PRIO_W'($urandom);
        endcase
    endfunction

    function automatic logic [OWNER_W-1:0] pick_owner();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return OWNER_W'($urandom);
        endcase
    endfunction

    task automatic send_word(op_t op, logic [OWNER_W-1:0] owner, logic [TASK_ID_W-1:0] slot,
            logic [PRIO_W-1:0] prio, logic fixed, task_result_t fixed_result);
        task_result_t predicted;
        int           gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_op            <= op;
        s_owner_id      <= owner;
        s_task_slot     <= slot;
        s_task_priority <= prio;
        do @(posedge aclk); while (!s_ready);
        predicted = run_task_word(op, owner, slot, prio);
        owed_results.push_back(fixed ? fixed_result : predicted);
        ops_sent[int'(op)]++;
        words_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic send_task_batch();
        logic [TASK_ID_W-1:0] added [$];
        logic [TASK_ID_W-1:0] slot;
        int                   adds;
        int                   execs;
        adds = $urandom_range(1, 10);
        for (int n = 0; n < adds; n++) begin
            slot = pick_slot();
            added.push_back(slot);
            send_word(OP_ADD, pick_owner(), slot, pick_prio(), 1'b0, '0);
            if ($urandom_range(0, 3) == 0) begin
                send_word(OP_EDIT, pick_owner(), added[$urandom_range(0, added.size() - 1)],
                          pick_prio(), 1'b0, '0);
            end
            if ($urandom_range(0, 4) == 0) begin
                send_word(OP_REMOVE, pick_owner(), added[$urandom_range(0, added.size() - 1)],
                          pick_prio(), 1'b0, '0);
            end
        end
        execs = $urandom_range(1, adds + 2);
        repeat (execs) send_word(OP_EXEC, pick_owner(), pick_slot(), pick_prio(), 1'b0, '0);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(3, 8)) begin
            send_word(op_t'($urandom_range(0, 3)), pick_owner(), pick_slot(), pick_prio(),
                      1'b0, '0);
        end
    endtask

    always @(negedge aclk) begin
        if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pattern <= 16'hFFFF;
                1: stall_pattern <= 16'($urandom) | 16'h0001;
                2: stall_pattern <= 16'h0001 << $urandom_range(0, 15);
                default: stall_pattern <= 16'($urandom | $urandom) | 16'h8000;
            endcase
            pattern_age <= $urandom_range(50, 400);
        end else begin
            stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
            pattern_age   <= pattern_age - 1;
        end
        m_ready <= stall_pattern[0];
    end

    always @(posedge aclk) begin
        task_result_t want;
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (aresetn && m_valid && m_ready) begin
            if (owed_results.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_MAX) begin
                    $display("Unexpected result word: found=%0b top_owner=%h",
                             m_found, m_top_owner);
                end
            end else begin
                want = owed_results.pop_front();
                results_seen++;
                if (m_found !== want.found || m_top_owner !== want.owner) begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX) begin
                        $display("Result %0d: expected %0b/%h, got %0b/%h",
                                 results_seen, want.found, want.owner, m_found, m_top_owner);
                    end
                end
            end
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("Watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        bit drained_mid;
        drained_mid = 1'b0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            slot_live[i]  = 1'b0;
            slot_prio[i]  = '0;
            slot_owner[i] = '0;
        end
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_word(DIRECTED_WORDS[r].op, DIRECTED_WORDS[r].owner, DIRECTED_WORDS[r].slot,
                      DIRECTED_WORDS[r].prio, DIRECTED_WORDS[r].fixed,
                      '{DIRECTED_WORDS[r].found, DIRECTED_WORDS[r].top_owner});
        end
        wait_for_results();

        while (words_sent < DIRECTED_ROWS + RANDOM_WORDS) begin
            if (!drained_mid && words_sent >= DIRECTED_ROWS + RANDOM_WORDS / 2) begin
                wait_for_results();
                drained_mid = 1'b1;
            end
            if ($urandom_range(0, 9) < 8) begin
                send_task_batch();
            end else begin
                send_noise();
            end
        end
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d words (%0d add, %0d edit, %0d remove, %0d execute-top), %0d checked.",
                 words_sent, ops_sent[0], ops_sent[1], ops_sent[2], ops_sent[3], results_seen);
        $display("Execute-top found a live task %0d times and an empty table %0d times.",
                 exec_hits, exec_empty);
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/imtq_pkg.sv
rtl/imtq_front.sv
rtl/imtq_back.sv
rtl/indexed_max_task_queue_core.sv
verif/indexed_max_task_queue_core_tb.sv
